// ===== rtl/bc_pkg.sv =====
// bc_pkg: shared types, constants and helpers for the barometer compensation block
// no dependencies
package bc_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_CHK,
    ST_T_DIV,
    ST_P_SQ,
    ST_P_M2,
    ST_P_M3,
    ST_P_M4,
    ST_P_M5,
    ST_P_M6,
    ST_P_M7,
    ST_P_DIV,
    ST_P_M8,
    ST_P_M9,
    ST_P_M10,
    ST_OUT
  } bc_state_t;

  // configuration register indexes
  localparam logic [1:0] CFG_CAL_A = 2'd0;
  localparam logic [1:0] CFG_CAL_B = 2'd1;
  localparam logic [1:0] CFG_CAL_C = 2'd2;
  localparam logic [1:0] CFG_OSS   = 2'd3;

  // transaction kinds
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  // algorithm constants
  localparam logic [31:0] C_4000  = 32'd4000;
  localparam logic [31:0] C_32768 = 32'd32768;
  localparam logic [31:0] C_50000 = 32'd50000;
  localparam logic [31:0] C_3038  = 32'd3038;
  localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
  localparam logic [31:0] C_3791  = 32'd3791;

  // arithmetic shift right
  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] k);
    return 32'($signed(v) >>> k);
  endfunction

  // signed division by 2^k truncating toward zero
  function automatic logic [31:0] sdiv_pow2(input logic [31:0] v, input logic [4:0] k);
    logic [31:0] bias;
    bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return 32'($signed(v + bias) >>> k);
  endfunction

  // sign extension of a 16-bit calibration field
  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== rtl/bc_divider.sv =====
// bc_divider: 32-bit unsigned restoring divider, one quotient bit per cycle
// depends on nothing
module bc_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  // one restoring step
  always_comb begin
    rem_sh   = {rem_r, quo_r[31]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge       = !diff[33];
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = 32'd0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : rem_sh[31:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== rtl/barometer_compensation.sv =====
// barometer_compensation: top level, sequencer around one shared 32x32 multiplier
// depends on bc_pkg and bc_divider
// a zero divisor skips the divide
// one transaction at a time; the divide takes up most of the latency
// in_stall is high from accept until the result is taken
// synchronous active-low reset clears calibration, oversampling, stored b5 and control
module barometer_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [23:0]        in_raw_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [31:0] out_value,
  output logic               out_divide_error
);

  bc_pkg::bc_state_t state_r, state_nxt;

  logic [63:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;
  logic [31:0] ti_r, ti_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] raw_r, raw_nxt;
  logic [31:0] w0_r, w0_nxt;
  logic [31:0] w1_r, w1_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [31:0] b3_r, b3_nxt;
  logic [31:0] b4_r, b4_nxt;
  logic [31:0] p_r, p_nxt;
  logic        flag_r, flag_nxt;
  logic [31:0] val_r, val_nxt;
  logic        err_r, err_nxt;

  logic [31:0] mul_a, mul_b, prod;
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, b6;
  logic [31:0] tmp, tmp2, den, num;

  // calibration fields
  assign ac1 = bc_pkg::sext16(cal_a_r[15:0]);
  assign ac2 = bc_pkg::sext16(cal_a_r[31:16]);
  assign ac3 = bc_pkg::sext16(cal_a_r[47:32]);
  assign ac4 = {16'd0, cal_a_r[63:48]};
  assign ac5 = {16'd0, cal_b_r[15:0]};
  assign ac6 = {16'd0, cal_b_r[31:16]};
  assign b1  = bc_pkg::sext16(cal_b_r[47:32]);
  assign b2  = bc_pkg::sext16(cal_b_r[63:48]);
  assign mc  = bc_pkg::sext16(cal_c_r[15:0]);
  assign md  = bc_pkg::sext16(cal_c_r[31:16]);
  assign b6  = ti_r - bc_pkg::C_4000;

  // the shared multiplier, low 32 bits
  assign prod = mul_a * mul_b;

  bc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .done     (div_done)
  );

  // sequencer: next state, multiplier operands, working registers
  always_comb begin
    state_nxt = state_r;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    div_start = 1'b0;
    div_a     = 32'd0;
    div_b     = 32'd0;
    ti_nxt    = ti_r;
    kind_nxt  = kind_r;
    raw_nxt   = raw_r;
    w0_nxt    = w0_r;
    w1_nxt    = w1_r;
    sq_nxt    = sq_r;
    b3_nxt    = b3_r;
    b4_nxt    = b4_r;
    p_nxt     = p_r;
    flag_nxt  = flag_r;
    val_nxt   = val_r;
    err_nxt   = err_r;
    tmp       = 32'd0;
    tmp2      = 32'd0;
    den       = w0_r + md;
    num       = mc << 11;
    unique case (state_r)
      bc_pkg::ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_action;
          raw_nxt   = {8'd0, in_raw_sample};
          state_nxt = (in_action == bc_pkg::KIND_TEMP) ? bc_pkg::ST_T_MUL : bc_pkg::ST_P_SQ;
        end
      end
      // x1 = ((ut - ac6) * ac5) / 32768
      bc_pkg::ST_T_MUL: begin
        mul_a     = raw_r - ac6;
        mul_b     = ac5;
        w0_nxt    = bc_pkg::sdiv_pow2(prod, 5'd15);
        state_nxt = bc_pkg::ST_T_CHK;
      end
      // x2 = mc * 2048 / (x1 + md), signed through magnitudes
      bc_pkg::ST_T_CHK: begin
        if (den == 32'd0) begin
          val_nxt   = 32'd0;
          err_nxt   = 1'b1;
          state_nxt = bc_pkg::ST_OUT;
        end else begin
          div_start = 1'b1;
          div_a     = num[31] ? (32'd0 - num) : num;
          div_b     = den[31] ? (32'd0 - den) : den;
          flag_nxt  = num[31] ^ den[31];
          state_nxt = bc_pkg::ST_T_DIV;
        end
      end
      bc_pkg::ST_T_DIV: begin
        if (div_done) begin
          tmp       = w0_r + (flag_r ? (32'd0 - div_q) : div_q);
          ti_nxt    = tmp;
          val_nxt   = bc_pkg::asr(tmp + 32'd8, 5'd4);
          err_nxt   = 1'b0;
          state_nxt = bc_pkg::ST_OUT;
        end
      end
      // sq = b6^2 >> 12
      bc_pkg::ST_P_SQ: begin
        mul_a     = b6;
        mul_b     = b6;
        sq_nxt    = bc_pkg::asr(prod, 5'd12);
        state_nxt = bc_pkg::ST_P_M2;
      end
      bc_pkg::ST_P_M2: begin
        mul_a     = sq_r;
        mul_b     = b2;
        w0_nxt    = bc_pkg::asr(prod, 5'd11);
        state_nxt = bc_pkg::ST_P_M3;
      end
      // b3 from x3 and ac1
      bc_pkg::ST_P_M3: begin
        mul_a     = b6;
        mul_b     = ac2;
        tmp       = w0_r + bc_pkg::asr(prod, 5'd11);
        tmp2      = (((ac1 << 2) + tmp) << oss_r) + 32'd2;
        b3_nxt    = bc_pkg::sdiv_pow2(tmp2, 5'd2);
        state_nxt = bc_pkg::ST_P_M4;
      end
      bc_pkg::ST_P_M4: begin
        mul_a     = ac3;
        mul_b     = b6;
        w0_nxt    = bc_pkg::asr(prod, 5'd13);
        state_nxt = bc_pkg::ST_P_M5;
      end
      bc_pkg::ST_P_M5: begin
        mul_a     = sq_r;
        mul_b     = b1;
        tmp       = bc_pkg::asr(w0_r + bc_pkg::asr(prod, 5'd16) + 32'd2, 5'd2);
        w1_nxt    = tmp + bc_pkg::C_32768;
        state_nxt = bc_pkg::ST_P_M6;
      end
      bc_pkg::ST_P_M6: begin
        mul_a     = w1_r;
        mul_b     = ac4;
        b4_nxt    = prod >> 15;
        state_nxt = bc_pkg::ST_P_M7;
      end
      // b7 and divide launch; a zero b4 skips to the output
      bc_pkg::ST_P_M7: begin
        if (b4_r == 32'd0) begin
          val_nxt   = 32'd0;
          err_nxt   = 1'b1;
          state_nxt = bc_pkg::ST_OUT;
        end else begin
          mul_a     = raw_r - b3_r;
          mul_b     = bc_pkg::C_50000 >> oss_r;
          div_start = 1'b1;
          div_a     = prod[31] ? prod : (prod << 1);
          div_b     = b4_r;
          flag_nxt  = prod[31];
          state_nxt = bc_pkg::ST_P_DIV;
        end
      end
      bc_pkg::ST_P_DIV: begin
        if (div_done) begin
          p_nxt     = flag_r ? (div_q << 1) : div_q;
          state_nxt = bc_pkg::ST_P_M8;
        end
      end
      bc_pkg::ST_P_M8: begin
        mul_a     = bc_pkg::asr(p_r, 5'd8);
        mul_b     = bc_pkg::asr(p_r, 5'd8);
        w0_nxt    = prod;
        state_nxt = bc_pkg::ST_P_M9;
      end
      bc_pkg::ST_P_M9: begin
        mul_a     = w0_r;
        mul_b     = bc_pkg::C_3038;
        w0_nxt    = bc_pkg::asr(prod, 5'd16);
        state_nxt = bc_pkg::ST_P_M10;
      end
      // final correction
      bc_pkg::ST_P_M10: begin
        mul_a     = bc_pkg::C_M7357;
        mul_b     = p_r;
        tmp       = w0_r + bc_pkg::asr(prod, 5'd16) + bc_pkg::C_3791;
        val_nxt   = p_r + bc_pkg::sdiv_pow2(tmp, 5'd4);
        err_nxt   = 1'b0;
        state_nxt = bc_pkg::ST_OUT;
      end
      bc_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = bc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bc_pkg::ST_IDLE;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bc_pkg::ST_IDLE;
      cal_a_r <= 64'd0;
      cal_b_r <= 64'd0;
      cal_c_r <= 32'd0;
      oss_r   <= 2'd0;
      ti_r    <= 32'd0;
    end else begin
      state_r <= state_nxt;
      ti_r    <= ti_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          bc_pkg::CFG_CAL_A: cal_a_r <= cfg_wdata;
          bc_pkg::CFG_CAL_B: cal_b_r <= cfg_wdata;
          bc_pkg::CFG_CAL_C: cal_c_r <= cfg_wdata[31:0];
          bc_pkg::CFG_OSS:   oss_r   <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    raw_r  <= raw_nxt;
    w0_r   <= w0_nxt;
    w1_r   <= w1_nxt;
    sq_r   <= sq_nxt;
    b3_r   <= b3_nxt;
    b4_r   <= b4_nxt;
    p_r    <= p_nxt;
    flag_r <= flag_nxt;
    val_r  <= val_nxt;
    err_r  <= err_nxt;
  end

  assign in_stall         = (state_r != bc_pkg::ST_IDLE);
  assign out_valid        = (state_r == bc_pkg::ST_OUT);
  assign out_kind         = kind_r;
  assign out_value        = val_r;
  assign out_divide_error = err_r;

endmodule

// ===== bench/barometer_compensation_checker.sv =====
`timescale 1ns / 1ps
// barometer_compensation_checker: watches the sample and result channels, predicts
// compensated temperature and pressure, and counts mismatches; depends on bc_pkg
module barometer_compensation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_action,
  input  logic [23:0]        in_raw_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_kind,
  input  logic signed [31:0] out_value,
  input  logic               out_divide_error,
  output int                 errors,
  output int                 pending,
  output int                 temp_results,
  output int                 press_results,
  output int                 div_errors
);

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        div_err;
  } reading_t;

  reading_t    expected_readings[$];
  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c, b5;
  logic [1:0]  oss;

  assign pending = expected_readings.size();

  function automatic logic [31:0] sx(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
    if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
    return $signed(a) / $signed(b);
  endfunction

  // temperature: updates stored b5 unless the divisor is zero
  function automatic reading_t comp_temperature(input logic [31:0] ut);
    reading_t r;
    logic [31:0] x1, den, x2, t5;
    r.kind = bc_pkg::KIND_TEMP;
    x1 = div_trunc((ut - {16'd0, cal_b[31:16]}) * {16'd0, cal_b[15:0]}, 32'd32768);
    den = x1 + sx(cal_c[31:16]);
    if (den == 0) begin
      r.value = 0;
      r.div_err = 1;
    end else begin
      x2 = div_trunc(sx(cal_c[15:0]) * 32'd2048, den);
      t5 = x1 + x2;
      b5 = t5;
      r.value = shr_s(t5 + 32'd8, 4);
      r.div_err = 0;
    end
    return r;
  endfunction

  // pressure: uses stored b5 and oversampling
  function automatic reading_t comp_pressure(input logic [31:0] up);
    reading_t r;
    logic [31:0] b6, sq, x1, x2, x3, b3, b4, b7, p, t;
    r.kind = bc_pkg::KIND_PRESS;
    b6 = b5 - 32'd4000;
    sq = shr_s(b6 * b6, 12);
    x1 = shr_s(sq * sx(cal_b[63:48]), 11);
    x2 = shr_s(b6 * sx(cal_a[31:16]), 11);
    x3 = x1 + x2;
    b3 = div_trunc(((sx(cal_a[15:0]) * 32'd4 + x3) << oss) + 32'd2, 32'd4);
    x1 = shr_s(sx(cal_a[47:32]) * b6, 13);
    x2 = shr_s(sq * sx(cal_b[47:32]), 16);
    x3 = shr_s(x1 + x2 + 32'd2, 2);
    b4 = ((x3 + 32'd32768) * {16'd0, cal_a[63:48]}) >> 15;
    if (b4 == 0) begin
      r.value = 0;
      r.div_err = 1;
      return r;
    end
    b7 = (up - b3) * (32'd50000 >> oss);
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    t = shr_s(p, 8);
    x1 = shr_s(t * t * 32'd3038, 16);
    x2 = shr_s((32'd0 - 32'd7357) * p, 16);
    p = p + div_trunc(x1 + x2 + 32'd3791, 32'd16);
    r.value = p;
    r.div_err = 0;
    return r;
  endfunction

  // register writes, sample predictions, result comparison
  always @(posedge clk) begin
    reading_t e;
    if (!rst_n) begin
      cal_a <= 0; cal_b <= 0; cal_c <= 0; oss <= 0; b5 = 0;
      expected_readings.delete();
      errors <= 0; temp_results <= 0; press_results <= 0; div_errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          bc_pkg::CFG_CAL_A: cal_a <= cfg_wdata;
          bc_pkg::CFG_CAL_B: cal_b <= cfg_wdata;
          bc_pkg::CFG_CAL_C: cal_c <= cfg_wdata[31:0];
          bc_pkg::CFG_OSS:   oss <= cfg_wdata[1:0];
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_action == bc_pkg::KIND_TEMP) e = comp_temperature({8'd0, in_raw_sample});
        else e = comp_pressure({8'd0, in_raw_sample});
        expected_readings.push_back(e);
      end
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result kind=%0b value=%0d", $time, out_kind, out_value);
          errors <= errors + 1;
        end else begin
          e = expected_readings.pop_front();
          if (out_kind !== e.kind || out_value !== e.value ||
              out_divide_error !== e.div_err) begin
            $display("%0t: expected %0b/%0d/%0b actual %0b/%0d/%0b",
                     $time, e.kind, $signed(e.value), e.div_err,
                     out_kind, out_value, out_divide_error);
            errors <= errors + 1;
          end
          if (e.kind == bc_pkg::KIND_TEMP) temp_results <= temp_results + 1;
          else press_results <= press_results + 1;
          if (e.div_err) div_errors <= div_errors + 1;
        end
      end
    end
  end

endmodule

// ===== bench/barometer_compensation_tb.sv =====
`timescale 1ns / 1ps
// barometer_compensation_tb: clock, reset, calibration writes and sample stimulus
// depends on bc_pkg, barometer_compensation and barometer_compensation_checker
module barometer_compensation_tb;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = bc_pkg::CFG_CAL_A;
  logic [63:0] cfg_wdata = 0;
  logic in_valid = 0, in_action = 0;
  logic [23:0] in_raw_sample = 0;
  logic in_stall, out_valid, out_stall = 0, out_kind, out_divide_error;
  logic signed [31:0] out_value;
  int errors, pending, temp_results, press_results, div_errors;
  int idle_cycles = 0;
  int burst_left = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  barometer_compensation dut (.*);
  barometer_compensation_checker u_checker (.*);

  // receiver stall pattern: alternating quiet stretches and random stalling
  always @(posedge clk) begin
    int phase;
    phase = int'(($time / 6000) % 3);
    out_stall <= (phase == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
  end

  // watchdog on cycles with no accepted transaction while work is waiting
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (!in_valid && pending == 0))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // one sample, with burst and gap idling
  task automatic send_sample(input logic act, input logic [23:0] raw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1; in_action <= act; in_raw_sample <= raw;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // plausible datasheet-like calibration with random jitter
  task automatic typical_cal(input logic [1:0] o);
    write_reg(bc_pkg::CFG_CAL_A,
              {16'(32741 + $urandom_range(0, 400)), 16'(-14383 + $urandom_range(0, 50)),
               16'(-1072 + $urandom_range(0, 50)), 16'(408 + $urandom_range(0, 50))});
    write_reg(bc_pkg::CFG_CAL_B,
              {16'(4 + $urandom_range(0, 8)), 16'(6190 + $urandom_range(0, 50)),
               16'(23153 + $urandom_range(0, 50)), 16'(32757 + $urandom_range(0, 50))});
    write_reg(bc_pkg::CFG_CAL_C, {16'(2868 + $urandom_range(0, 50)),
                                  16'(-8711 + $urandom_range(0, 50))});
    write_reg(bc_pkg::CFG_OSS, 64'(o));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // pressure before any temperature, all-zero calibration: zero divisor
    send_sample(bc_pkg::KIND_PRESS, 24'h123456);
    send_sample(bc_pkg::KIND_TEMP, 24'h000000);
    drain();

    typical_cal(2'd0);
    send_sample(bc_pkg::KIND_TEMP, 24'd27898);
    send_sample(bc_pkg::KIND_PRESS, 24'd23843);
    send_sample(bc_pkg::KIND_TEMP, 24'hFFFFFF);
    send_sample(bc_pkg::KIND_PRESS, 24'hFFFFFF);
    send_sample(bc_pkg::KIND_TEMP, 24'h000000);
    send_sample(bc_pkg::KIND_PRESS, 24'h000000);
    send_sample(bc_pkg::KIND_TEMP, 24'h010000);
    drain();

    // zero temperature divisor: ac5 = 0 makes x1 = 0, md = 0
    write_reg(bc_pkg::CFG_CAL_B, 64'h7FF5_5A71_1838_0000);
    write_reg(bc_pkg::CFG_CAL_C, 64'h0000_D4BD);
    send_sample(bc_pkg::KIND_TEMP, 24'd30000);
    send_sample(bc_pkg::KIND_PRESS, 24'd40000);
    drain();

    // extremes of every register, large b7 and zero b4
    write_reg(bc_pkg::CFG_CAL_A, 64'hFFFF_8000_7FFF_8000);
    write_reg(bc_pkg::CFG_CAL_B, 64'h7FFF_8000_FFFF_FFFF);
    write_reg(bc_pkg::CFG_CAL_C, 64'h7FFF_8000);
    write_reg(bc_pkg::CFG_OSS, 64'd3);
    send_sample(bc_pkg::KIND_TEMP, 24'h00FFFF);
    send_sample(bc_pkg::KIND_PRESS, 24'h000001);
    send_sample(bc_pkg::KIND_PRESS, 24'hFFFFFF);
    drain();
    write_reg(bc_pkg::CFG_CAL_A, 64'h0000_0000_0000_0001);
    write_reg(bc_pkg::CFG_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bc_pkg::CFG_CAL_C, 64'hFFFF_FFFF);
    write_reg(bc_pkg::CFG_OSS, 64'd0);
    send_sample(bc_pkg::KIND_TEMP, 24'h5A5A5A);
    send_sample(bc_pkg::KIND_PRESS, 24'hA5A5A5);
    drain();

    // random phases: mostly realistic calibration, some fully random
    for (int ph = 0; ph < 13; ph++) begin
      if (ph % 4 == 3) begin
        write_reg(bc_pkg::CFG_CAL_A, {$urandom, $urandom});
        write_reg(bc_pkg::CFG_CAL_B, {$urandom, $urandom});
        write_reg(bc_pkg::CFG_CAL_C, 64'($urandom));
        write_reg(bc_pkg::CFG_OSS, 64'($urandom_range(0, 3)));
      end else typical_cal(2'(ph % 4));
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(1'($urandom_range(0, 1)), 24'($urandom));
        else if ($urandom_range(0, 2) == 0)
          send_sample(bc_pkg::KIND_TEMP, 24'($urandom_range(20000, 36000)));
        else
          send_sample(bc_pkg::KIND_PRESS,
                      24'($urandom_range(15000, 45000) << $urandom_range(0, 3)));
      end
      drain();
    end

    $display("covered %0d temperature and %0d pressure results, %0d divide errors",
             temp_results, press_results, div_errors);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bc_pkg.sv
rtl/bc_divider.sv
rtl/barometer_compensation.sv
bench/barometer_compensation_checker.sv
bench/barometer_compensation_tb.sv
